[rtl/ipmdq_pkg.sv]
// Shared types, constants and saturating fixed-point helpers for the IPM dq derivative core.
package ipmdq_pkg;

    // Default configuration of the core
    localparam int DQ_FRAC_BITS  = 16;
    localparam int DQ_SINE_DEPTH = 1024;
    // Register stages from input transaction to output register
    localparam int DQ_LAT        = 9;
    localparam int DQ_REG_W      = 31;
    localparam int DQ_IDX_W      = 3;

    typedef logic signed [31:0] t_q;

    localparam t_q Q_MAX = 32'sh7fff_ffff;
    localparam t_q Q_MIN = 32'sh8000_0000;

    // Configuration register indexes
    typedef enum logic [DQ_IDX_W-1:0] {
        REG_RES,
        REG_IND_D,
        REG_IND_Q,
        REG_FLUX,
        REG_INV_IND_D,
        REG_INV_IND_Q,
        REG_INV_INERTIA
    } t_reg_idx;

    typedef struct packed {
        t_q          cur_d;
        t_q          cur_q;
        t_q          speed;
        logic [15:0] angle;
        t_q          v_alpha;
        t_q          v_beta;
        t_q          load_torque;
    } t_in;

    typedef struct packed {
        t_q dcur_d;
        t_q dcur_q;
        t_q dspeed;
        t_q dangle;
        t_q torque;
    } t_out;

    // Full signed product
    function automatic logic signed [63:0] q_mul(input t_q a, input t_q b);
        return 64'(a) * 64'(b);
    endfunction

    // Clamp a wide value to the 32-bit signed range
    function automatic t_q q_sat64(input logic signed [63:0] v);
        if (v > 64'(Q_MAX)) begin
            return Q_MAX;
        end else if (v < 64'(Q_MIN)) begin
            return Q_MIN;
        end
        return v[31:0];
    endfunction

    // Drop the fraction bits (floor) and saturate
    function automatic t_q q_fix(input logic signed [63:0] p, input int unsigned frac);
        logic signed [63:0] s;
        s = p >>> frac;
        return q_sat64(s);
    endfunction

    function automatic t_q q_sat33(input logic signed [32:0] v);
        if (v > 33'(Q_MAX)) begin
            return Q_MAX;
        end else if (v < 33'(Q_MIN)) begin
            return Q_MIN;
        end
        return v[31:0];
    endfunction

    function automatic t_q q_add(input t_q a, input t_q b);
        logic signed [32:0] s;
        s = 33'(a) + 33'(b);
        return q_sat33(s);
    endfunction

    function automatic t_q q_sub(input t_q a, input t_q b);
        logic signed [32:0] s;
        s = 33'(a) - 33'(b);
        return q_sat33(s);
    endfunction

    function automatic t_q q_neg(input t_q a);
        return (a == Q_MIN) ? Q_MAX : -a;
    endfunction

endpackage

[rtl/ipm_motor_dq_derivatives_core.sv]
// Top level: pipelined dq-frame derivative evaluator for an IPM motor model.
//
//  channel   direction  handshake            payload
//  input     in         i_valid / o_ready    i_data (t_in)
//  output    out        o_valid / i_ready    o_data (t_out)
//  config    in         i_cfg_we             i_cfg_idx, i_cfg_data
//
// Nine register stages; one transaction per cycle sustained while the output is not stalled.
// Multipliers and saturation alternate across stages; sin/cos come from two
// constant ROMs read in the first stage.
// Synchronous active-low reset clears the stage valid bits and the config registers.
// Each stage loads when it is empty or the stage after it moves, so an output
// stall only holds back the stages behind it and bubbles still fill.
module ipm_motor_dq_derivatives_core
    import ipmdq_pkg::*;
#(
    parameter int FRAC_BITS  = DQ_FRAC_BITS,
    parameter int SINE_DEPTH = DQ_SINE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input transactions
    input  logic                i_valid,
    output logic                o_ready,
    input  t_in                 i_data,
    // result transactions
    output logic                o_valid,
    input  logic                i_ready,
    output t_out                o_data,
    // configuration writes
    input  logic                i_cfg_we,
    input  logic [DQ_IDX_W-1:0] i_cfg_idx,
    input  logic [DQ_REG_W-1:0] i_cfg_data
);

    localparam int SW    = FRAC_BITS + 2;
    localparam int KW    = $clog2(SINE_DEPTH);
    localparam int NSTG  = DQ_LAT;
    localparam logic [63:0] Q30_ONE = 64'd1073741824;
    localparam logic [63:0] HALF_PI = 64'd1686629713;

    typedef logic signed [SW-1:0] t_tab [SINE_DEPTH];

    // Q30 Taylor sine on the folded quarter wave, rounded to FRAC_BITS
    function automatic logic signed [SW-1:0] sine_of(input logic [31:0] ph);
        logic [1:0]           quad;
        logic [63:0]          r;
        logic [63:0]          x;
        logic [63:0]          x2;
        logic [63:0]          t;
        logic [63:0]          s;
        logic signed [SW-1:0] v;
        quad = ph[31:30];
        r    = {34'd0, ph[29:0]};
        if (quad[0]) begin
            r = Q30_ONE - r;
        end
        x  = (r * HALF_PI) >> 30;
        x2 = (x * x) >> 30;
        t  = Q30_ONE;
        t  = Q30_ONE - ((x2 * t) >> 30) / 72;
        t  = Q30_ONE - ((x2 * t) >> 30) / 42;
        t  = Q30_ONE - ((x2 * t) >> 30) / 20;
        t  = Q30_ONE - ((x2 * t) >> 30) / 6;
        s  = (x * t) >> 30;
        s  = (s + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
        if (s > (64'd1 << FRAC_BITS)) begin
            s = 64'd1 << FRAC_BITS;
        end
        v = SW'(s);
        return quad[1] ? -v : v;
    endfunction

    // Table of sin (or cos, a quarter turn on) per phase step
    function automatic t_tab build_tab(input logic cos_sel);
        t_tab        tab;
        logic [31:0] ph;
        for (int k = 0; k < SINE_DEPTH; k++) begin
            ph = 32'((64'(k) << 32) / SINE_DEPTH);
            if (cos_sel) begin
                ph = ph + 32'h4000_0000;
            end
            tab[k] = sine_of(ph);
        end
        return tab;
    endfunction

    localparam t_tab SIN_TAB = build_tab(1'b0);
    localparam t_tab COS_TAB = build_tab(1'b1);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [DQ_REG_W-1:0] r_res, r_ind_d, r_ind_q, r_flux;
    logic [DQ_REG_W-1:0] r_inv_ind_d, r_inv_ind_q, r_inv_inertia;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res         <= '0;
            r_ind_d       <= '0;
            r_ind_q       <= '0;
            r_flux        <= '0;
            r_inv_ind_d   <= '0;
            r_inv_ind_q   <= '0;
            r_inv_inertia <= '0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_RES:         r_res         <= i_cfg_data;
                REG_IND_D:       r_ind_d       <= i_cfg_data;
                REG_IND_Q:       r_ind_q       <= i_cfg_data;
                REG_FLUX:        r_flux        <= i_cfg_data;
                REG_INV_IND_D:   r_inv_ind_d   <= i_cfg_data;
                REG_INV_IND_Q:   r_inv_ind_q   <= i_cfg_data;
                REG_INV_INERTIA: r_inv_inertia <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Registers as non-negative signed operands
    t_q c_res, c_ind_d, c_ind_q, c_flux, c_ild, c_ilq, c_iin;
    assign c_res   = t_q'({1'b0, r_res});
    assign c_ind_d = t_q'({1'b0, r_ind_d});
    assign c_ind_q = t_q'({1'b0, r_ind_q});
    assign c_flux  = t_q'({1'b0, r_flux});
    assign c_ild   = t_q'({1'b0, r_inv_ind_d});
    assign c_ilq   = t_q'({1'b0, r_inv_ind_q});
    assign c_iin   = t_q'({1'b0, r_inv_inertia});

    // ---------------------------------------------------------------
    // Stage flow control: a stage loads when empty or when it drains
    // ---------------------------------------------------------------
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] n_vld;
    logic [NSTG-1:0] stg_en;

    always_comb begin
        stg_en[NSTG-1] = !r_vld[NSTG-1] || i_ready;
        for (int s = NSTG - 2; s >= 0; s--) begin
            stg_en[s] = !r_vld[s] || stg_en[s+1];
        end
    end

    assign n_vld = (stg_en & {r_vld[NSTG-2:0], i_valid}) | (~stg_en & r_vld);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_ready = stg_en[0];
    assign o_valid = r_vld[NSTG-1];

    // ---------------------------------------------------------------
    // S1: trig ROM read, first products
    // ---------------------------------------------------------------
    logic [KW-1:0] tab_idx;
    assign tab_idx = KW'((32'(i_data.angle) * 32'(SINE_DEPTH)) >> 16);

    logic signed [SW-1:0] r_s1_sin, r_s1_cos;
    logic signed [63:0]   r_s1_p_rid, r_s1_p_lqiq, r_s1_p_riq, r_s1_p_ldid;
    logic signed [63:0]   r_s1_p_wke, r_s1_p_keiq, r_s1_p_idiq;
    t_q                   r_s1_w, r_s1_va, r_s1_vb, r_s1_tl, r_s1_ldlq;

    always_ff @(posedge i_clk) begin
        if (stg_en[0]) begin
            r_s1_sin    <= SIN_TAB[tab_idx];
            r_s1_cos    <= COS_TAB[tab_idx];
            r_s1_p_rid  <= q_mul(c_res, i_data.cur_d);
            r_s1_p_lqiq <= q_mul(c_ind_q, i_data.cur_q);
            r_s1_p_riq  <= q_mul(c_res, i_data.cur_q);
            r_s1_p_ldid <= q_mul(c_ind_d, i_data.cur_d);
            r_s1_p_wke  <= q_mul(i_data.speed, c_flux);
            r_s1_p_keiq <= q_mul(c_flux, i_data.cur_q);
            r_s1_p_idiq <= q_mul(i_data.cur_d, i_data.cur_q);
            r_s1_w      <= i_data.speed;
            r_s1_va     <= i_data.v_alpha;
            r_s1_vb     <= i_data.v_beta;
            r_s1_tl     <= i_data.load_torque;
            r_s1_ldlq   <= q_sub(c_ind_d, c_ind_q);
        end
    end

    // ---------------------------------------------------------------
    // S2: scale first products, Park products
    // ---------------------------------------------------------------
    t_q                 r_s2_rid, r_s2_lqiq, r_s2_riq, r_s2_ldid, r_s2_wke, r_s2_keiq;
    t_q                 r_s2_idiq, r_s2_w, r_s2_tl, r_s2_ldlq;
    logic signed [63:0] r_s2_p_vacs, r_s2_p_vbsn, r_s2_p_vasn, r_s2_p_vbcs;

    always_ff @(posedge i_clk) begin
        if (stg_en[1]) begin
            r_s2_rid    <= q_fix(r_s1_p_rid, FRAC_BITS);
            r_s2_lqiq   <= q_fix(r_s1_p_lqiq, FRAC_BITS);
            r_s2_riq    <= q_fix(r_s1_p_riq, FRAC_BITS);
            r_s2_ldid   <= q_fix(r_s1_p_ldid, FRAC_BITS);
            r_s2_wke    <= q_fix(r_s1_p_wke, FRAC_BITS);
            r_s2_keiq   <= q_fix(r_s1_p_keiq, FRAC_BITS);
            r_s2_idiq   <= q_fix(r_s1_p_idiq, FRAC_BITS);
            r_s2_p_vacs <= q_mul(r_s1_va, 32'(r_s1_cos));
            r_s2_p_vbsn <= q_mul(r_s1_vb, 32'(r_s1_sin));
            r_s2_p_vasn <= q_mul(r_s1_va, 32'(r_s1_sin));
            r_s2_p_vbcs <= q_mul(r_s1_vb, 32'(r_s1_cos));
            r_s2_w      <= r_s1_w;
            r_s2_tl     <= r_s1_tl;
            r_s2_ldlq   <= r_s1_ldlq;
        end
    end

    // ---------------------------------------------------------------
    // S3: speed and saliency products, scale Park products
    // ---------------------------------------------------------------
    logic signed [63:0] r_s3_p_wlqiq, r_s3_p_wldid, r_s3_p_trq2;
    t_q                 r_s3_vacs, r_s3_vbsn, r_s3_vasn, r_s3_vbcs;
    t_q                 r_s3_rid, r_s3_riq, r_s3_wke, r_s3_keiq, r_s3_w, r_s3_tl;

    always_ff @(posedge i_clk) begin
        if (stg_en[2]) begin
            r_s3_p_wlqiq <= q_mul(r_s2_w, r_s2_lqiq);
            r_s3_p_wldid <= q_mul(r_s2_w, r_s2_ldid);
            r_s3_p_trq2  <= q_mul(r_s2_ldlq, r_s2_idiq);
            r_s3_vacs    <= q_fix(r_s2_p_vacs, FRAC_BITS);
            r_s3_vbsn    <= q_fix(r_s2_p_vbsn, FRAC_BITS);
            r_s3_vasn    <= q_fix(r_s2_p_vasn, FRAC_BITS);
            r_s3_vbcs    <= q_fix(r_s2_p_vbcs, FRAC_BITS);
            r_s3_rid     <= r_s2_rid;
            r_s3_riq     <= r_s2_riq;
            r_s3_wke     <= r_s2_wke;
            r_s3_keiq    <= r_s2_keiq;
            r_s3_w       <= r_s2_w;
            r_s3_tl      <= r_s2_tl;
        end
    end

    // ---------------------------------------------------------------
    // S4: scale speed products, rotating-frame voltages
    // ---------------------------------------------------------------
    t_q r_s4_wlqiq, r_s4_wldid, r_s4_trq2, r_s4_vd, r_s4_vq;
    t_q r_s4_rid, r_s4_riq, r_s4_wke, r_s4_keiq, r_s4_w, r_s4_tl;

    always_ff @(posedge i_clk) begin
        if (stg_en[3]) begin
            r_s4_wlqiq <= q_fix(r_s3_p_wlqiq, FRAC_BITS);
            r_s4_wldid <= q_fix(r_s3_p_wldid, FRAC_BITS);
            r_s4_trq2  <= q_fix(r_s3_p_trq2, FRAC_BITS);
            r_s4_vd    <= q_add(r_s3_vacs, r_s3_vbsn);
            r_s4_vq    <= q_add(q_neg(r_s3_vasn), r_s3_vbcs);
            r_s4_rid   <= r_s3_rid;
            r_s4_riq   <= r_s3_riq;
            r_s4_wke   <= r_s3_wke;
            r_s4_keiq  <= r_s3_keiq;
            r_s4_w     <= r_s3_w;
            r_s4_tl    <= r_s3_tl;
        end
    end

    // ---------------------------------------------------------------
    // S5: first sums of the voltage equations, electrical torque
    // ---------------------------------------------------------------
    t_q r_s5_w11a, r_s5_w22a, r_s5_trq, r_s5_vd, r_s5_vq, r_s5_wke, r_s5_w, r_s5_tl;

    always_ff @(posedge i_clk) begin
        if (stg_en[4]) begin
            r_s5_w11a <= q_sub(r_s4_rid, r_s4_wlqiq);
            r_s5_w22a <= q_add(r_s4_riq, r_s4_wldid);
            r_s5_trq  <= q_add(r_s4_keiq, r_s4_trq2);
            r_s5_vd   <= r_s4_vd;
            r_s5_vq   <= r_s4_vq;
            r_s5_wke  <= r_s4_wke;
            r_s5_w    <= r_s4_w;
            r_s5_tl   <= r_s4_tl;
        end
    end

    // ---------------------------------------------------------------
    // S6: d-axis sum done, back-EMF term, net torque
    // ---------------------------------------------------------------
    t_q r_s6_w11, r_s6_w22b, r_s6_dwa, r_s6_vq, r_s6_trq, r_s6_w;

    always_ff @(posedge i_clk) begin
        if (stg_en[5]) begin
            r_s6_w11  <= q_sub(r_s5_w11a, r_s5_vd);
            r_s6_w22b <= q_add(r_s5_w22a, r_s5_wke);
            r_s6_dwa  <= q_sub(r_s5_trq, r_s5_tl);
            r_s6_vq   <= r_s5_vq;
            r_s6_trq  <= r_s5_trq;
            r_s6_w    <= r_s5_w;
        end
    end

    // ---------------------------------------------------------------
    // S7: q-axis sum done, reciprocal products for d and speed
    // ---------------------------------------------------------------
    t_q                 r_s7_w22, r_s7_trq, r_s7_w;
    logic signed [63:0] r_s7_p_dd, r_s7_p_dw;

    always_ff @(posedge i_clk) begin
        if (stg_en[6]) begin
            r_s7_w22  <= q_sub(r_s6_w22b, r_s6_vq);
            r_s7_p_dd <= q_mul(r_s6_w11, c_ild);
            r_s7_p_dw <= q_mul(r_s6_dwa, c_iin);
            r_s7_trq  <= r_s6_trq;
            r_s7_w    <= r_s6_w;
        end
    end

    // ---------------------------------------------------------------
    // S8: q reciprocal product, scale d and speed derivatives
    // ---------------------------------------------------------------
    logic signed [63:0] r_s8_p_dq;
    t_q                 r_s8_dd, r_s8_dw, r_s8_trq, r_s8_w;

    always_ff @(posedge i_clk) begin
        if (stg_en[7]) begin
            r_s8_p_dq <= q_mul(r_s7_w22, c_ilq);
            r_s8_dd   <= q_neg(q_fix(r_s7_p_dd, FRAC_BITS));
            r_s8_dw   <= q_fix(r_s7_p_dw, FRAC_BITS);
            r_s8_trq  <= r_s7_trq;
            r_s8_w    <= r_s7_w;
        end
    end

    // ---------------------------------------------------------------
    // S9: scale q derivative into the output register
    // ---------------------------------------------------------------
    t_out r_out;

    always_ff @(posedge i_clk) begin
        if (stg_en[8]) begin
            r_out.dcur_d <= r_s8_dd;
            r_out.dcur_q <= q_neg(q_fix(r_s8_p_dq, FRAC_BITS));
            r_out.dspeed <= r_s8_dw;
            r_out.dangle <= r_s8_w;
            r_out.torque <= r_s8_trq;
        end
    end

    assign o_data = r_out;

endmodule

[rtl/ipmdq_chk.sv]
// Port-level checker for the IPM dq derivative core, with its bind statement.
module ipmdq_chk
    import ipmdq_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_ready,
    input logic o_valid,
    input logic i_ready,
    input t_out o_data
);

    localparam int CW = $clog2(DQ_LAT + 1);

    // Transactions taken in but not yet delivered
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] n_cnt;

    assign n_cnt = r_cnt + CW'(i_valid && o_ready) - CW'(o_valid && i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result changed while stalled");

    // Reset empties the pipeline
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid straight after reset");

    // No result without an outstanding transaction
    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_cnt != '0)
        else $error("result without matching input transaction");

    // Empty pipeline always takes input
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == '0 |-> o_ready)
        else $error("input stalled with nothing in flight");

    // Never more in flight than stages
    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DQ_LAT))
        else $error("more transactions in flight than pipeline stages");

endmodule

bind ipm_motor_dq_derivatives_core ipmdq_chk u_ipmdq_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_data  (o_data)
);

[tb/sv/ipm_motor_dq_derivatives_core_tb.sv]
// Self-checking testbench for the IPM motor dq derivative core.
module ipm_motor_dq_derivatives_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ipmdq_pkg::*;

    localparam int NREG                = int'(REG_INV_INERTIA) + 1;
    localparam int FRAC                = DQ_FRAC_BITS;
    localparam longint unsigned DEPTH  = DQ_SINE_DEPTH;
    localparam longint unsigned Q30_ONE     = 64'd1073741824;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint FX_MAX          = 64'sd2147483647;
    localparam longint FX_MIN          = -64'sd2147483648;
    localparam int CYCLE_LIMIT         = 200000;
    // Index past the last register; writes to it must be ignored
    localparam logic [DQ_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;

    logic                i_clk      = 1'b0;
    logic                i_rst_n    = 1'b0;
    logic                i_valid    = 1'b0;
    logic                o_ready;
    t_in                 i_data     = '0;
    logic                o_valid;
    logic                i_ready    = 1'b0;
    t_out                o_data;
    logic                i_cfg_we   = 1'b0;
    logic [DQ_IDX_W-1:0] i_cfg_idx  = '0;
    logic [DQ_REG_W-1:0] i_cfg_data = '0;

    // Register mirror, the next set to load, and expected results in order
    logic [DQ_REG_W-1:0] cfg_reg  [NREG];
    logic [DQ_REG_W-1:0] reg_plan [NREG];
    t_out                pending_derivs [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_cycles    = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;

    ipm_motor_dq_derivatives_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_data     (o_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Fixed-point predictor
    // ---------------------------------------------------------------
    function automatic longint fx_clamp(input longint v);
        if (v > FX_MAX) return FX_MAX;
        if (v < FX_MIN) return FX_MIN;
        return v;
    endfunction

    // floor of the product over 2^FRAC, then clamp
    function automatic longint fx_mul(input longint a, input longint b);
        longint p;
        p = a * b;
        return fx_clamp(p >>> FRAC);
    endfunction

    function automatic longint fx_add(input longint a, input longint b);
        return fx_clamp(a + b);
    endfunction

    function automatic longint fx_sub(input longint a, input longint b);
        return fx_clamp(a - b);
    endfunction

    function automatic longint fx_neg(input longint a);
        return fx_clamp(-a);
    endfunction

    // Sine of a 32-bit turn fraction: Q30 Taylor series on the folded quarter wave
    function automatic longint turn_sine(input logic [31:0] ph);
        logic [1:0]      quad;
        longint unsigned r, x, x2, t, s;
        quad = ph[31:30];
        r = 64'(ph[29:0]);
        if (quad[0]) r = Q30_ONE - r;
        x  = (r * HALF_PI_Q30) >> 30;
        x2 = (x * x) >> 30;
        t  = Q30_ONE;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
        s  = (x * t) >> 30;
        s  = (s + (64'd1 << (29 - FRAC))) >> (30 - FRAC);
        if (s > (64'd1 << FRAC)) s = 64'd1 << FRAC;
        return quad[1] ? -longint'(s) : longint'(s);
    endfunction

    // Expected derivatives for one input transaction under the current registers
    function automatic t_out derive_dq(input t_in it);
        longint          id, iq, w, va, vb, tl;
        longint          res_r, ld, lq, ke, ild, ilq, iin;
        longint          sn, cs, vd, vq, w11, w22, trq;
        longint unsigned k;
        logic [31:0]     ph;
        t_out            res;
        id    = it.cur_d;
        iq    = it.cur_q;
        w     = it.speed;
        va    = it.v_alpha;
        vb    = it.v_beta;
        tl    = it.load_torque;
        res_r = cfg_reg[REG_RES];
        ld    = cfg_reg[REG_IND_D];
        lq    = cfg_reg[REG_IND_Q];
        ke    = cfg_reg[REG_FLUX];
        ild   = cfg_reg[REG_INV_IND_D];
        ilq   = cfg_reg[REG_INV_IND_Q];
        iin   = cfg_reg[REG_INV_INERTIA];

        // table phase and the Park rotation
        k  = (64'(it.angle) * DEPTH) >> 16;
        ph = 32'((k << 32) / DEPTH);
        sn = turn_sine(ph);
        cs = turn_sine(ph + 32'h4000_0000);
        vd = fx_add(fx_mul(va, cs), fx_mul(vb, sn));
        vq = fx_add(fx_neg(fx_mul(va, sn)), fx_mul(vb, cs));

        // dq voltage equations
        w11 = fx_sub(fx_sub(fx_mul(res_r, id), fx_mul(w, fx_mul(lq, iq))), vd);
        w22 = fx_sub(fx_add(fx_add(fx_mul(res_r, iq), fx_mul(w, fx_mul(ld, id))),
                            fx_mul(w, ke)), vq);
        trq = fx_add(fx_mul(ke, iq), fx_mul(fx_sub(ld, lq), fx_mul(id, iq)));

        res.dcur_d = t_q'(fx_neg(fx_mul(w11, ild)));
        res.dcur_q = t_q'(fx_neg(fx_mul(w22, ilq)));
        res.dspeed = t_q'(fx_mul(fx_sub(trq, tl), iin));
        res.dangle = it.speed;
        res.torque = t_q'(trq);
        return res;
    endfunction

    // ---------------------------------------------------------------
    // Monitors and checker
    // ---------------------------------------------------------------
    // register mirror follows the write port
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int n = 0; n < NREG; n++) cfg_reg[n] <= '0;
        end else if (i_cfg_we && int'(i_cfg_idx) < NREG) begin
            cfg_reg[i_cfg_idx] <= i_cfg_data;
        end
    end

    // predict on every accepted input transaction
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready) pending_derivs.push_back(derive_dq(i_data));
    end

    function automatic void check_field(input string fld, input t_q want, input t_q got);
        if (want !== got) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("mismatch %s: expected %0d (%h) got %0d (%h)",
                         fld, want, want, got, got);
        end
    endfunction

    // compare each result transaction with the oldest expectation
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_derivs.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result transaction: %h", o_data);
            end else begin
                want = pending_derivs.pop_front();
                check_field("dcur_d", want.dcur_d, o_data.dcur_d);
                check_field("dcur_q", want.dcur_q, o_data.dcur_q);
                check_field("dspeed", want.dspeed, o_data.dspeed);
                check_field("dangle", want.dangle, o_data.dangle);
                check_field("torque", want.torque, o_data.torque);
            end
        end
    end

    // receiver: random stalls, or a long hold-off when asked
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            i_ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Driving
    // ---------------------------------------------------------------
    // Offer one transaction and return at the edge that accepts it; valid is
    // left high so the next call can follow without a bubble.
    task automatic send_item(input t_in it);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= it;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // Stop offering and wait until every expected result is back; it first waits
    // for a clock edge so the last accepted transaction is already queued
    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_derivs.size() != 0) @(posedge i_clk);
        repeat (DQ_LAT + 2) @(posedge i_clk);
    endtask

    // Load reg_plan into all registers, then poke the unused index
    task automatic write_regs();
        t_reg_idx r;
        r = r.first();
        do begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= r;
            i_cfg_data <= reg_plan[r];
            @(posedge i_clk);
            r = r.next();
        end while (r != r.first());
        i_cfg_idx  <= CFG_IDX_UNUSED;
        i_cfg_data <= DQ_REG_W'($urandom);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_in mk_item(input t_q cd, input t_q cq, input t_q sp,
                                    input logic [15:0] ang, input t_q va,
                                    input t_q vb, input t_q tl);
        t_in it;
        it.cur_d       = cd;
        it.cur_q       = cq;
        it.speed       = sp;
        it.angle       = ang;
        it.v_alpha     = va;
        it.v_beta      = vb;
        it.load_torque = tl;
        return it;
    endfunction

    // mostly modest values, some full range, a few rails
    function automatic t_q rand_fx();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 55) return t_q'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
        if (pick < 90) return t_q'($urandom);
        if (pick < 94) return Q_MAX;
        if (pick < 97) return Q_MIN;
        return '0;
    endfunction

    function automatic t_in rand_item();
        return mk_item(rand_fx(), rand_fx(), rand_fx(), 16'($urandom_range(0, 65535)),
                       rand_fx(), rand_fx(), rand_fx());
    endfunction

    function automatic logic [DQ_REG_W-1:0] rand_reg();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 15) return '0;
        if (pick < 30) return '1;
        if (pick < 65) return DQ_REG_W'($urandom_range(0, 1 << 20));
        return DQ_REG_W'($urandom);
    endfunction

    task automatic plan_regs(input logic [DQ_REG_W-1:0] r, input logic [DQ_REG_W-1:0] ld,
                             input logic [DQ_REG_W-1:0] lq, input logic [DQ_REG_W-1:0] ke,
                             input logic [DQ_REG_W-1:0] ild,
                             input logic [DQ_REG_W-1:0] ilq,
                             input logic [DQ_REG_W-1:0] iin);
        reg_plan[REG_RES]         = r;
        reg_plan[REG_IND_D]       = ld;
        reg_plan[REG_IND_Q]       = lq;
        reg_plan[REG_FLUX]        = ke;
        reg_plan[REG_INV_IND_D]   = ild;
        reg_plan[REG_INV_IND_Q]   = ilq;
        reg_plan[REG_INV_INERTIA] = iin;
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    // registers still at their reset value of zero
    task automatic test_reset_regs();
        send_item(mk_item(Q_MAX, Q_MAX, Q_MAX, 16'hffff, Q_MAX, Q_MAX, Q_MAX));
        send_item(mk_item(Q_MIN, Q_MIN, Q_MIN, 16'h0000, Q_MIN, Q_MIN, Q_MIN));
        send_item(rand_item());
        settle();
    endtask

    // field extremes, quadrant and table-step angles, rounding of negatives
    task automatic test_field_extremes();
        plan_regs(31'd32768, 31'd19661, 31'd45875, 31'd6554,
                  31'd218453, 31'd93623, 31'd655360);
        write_regs();
        send_item(mk_item('0, '0, '0, 16'd0, '0, '0, '0));
        send_item(mk_item(Q_MAX, Q_MAX, Q_MAX, 16'hffff, Q_MAX, Q_MAX, Q_MAX));
        send_item(mk_item(Q_MIN, Q_MIN, Q_MIN, 16'd0, Q_MIN, Q_MIN, Q_MIN));
        send_item(mk_item(32'sd65536, 32'sd131072, 32'sd6553600, 16'd16384,
                          32'sd655360, -32'sd327680, 32'sd32768));
        send_item(mk_item(32'sd65536, 32'sd131072, -32'sd6553600, 16'd32768,
                          32'sd655360, -32'sd327680, 32'sd32768));
        send_item(mk_item(-32'sd65536, 32'sd131072, 32'sd6553600, 16'd49152,
                          32'sd655360, 32'sd327680, -32'sd32768));
        // just below and at the first table step, and an eighth turn
        send_item(mk_item(32'sd1000, 32'sd2000, 32'sd3000, 16'd63,
                          32'sd655360, 32'sd655360, '0));
        send_item(mk_item(32'sd1000, 32'sd2000, 32'sd3000, 16'd64,
                          32'sd655360, 32'sd655360, '0));
        send_item(mk_item(32'sd1000, 32'sd2000, 32'sd3000, 16'd8192,
                          32'sd655360, 32'sd655360, '0));
        // saturation of the inner products
        send_item(mk_item(Q_MAX, Q_MIN, Q_MAX, 16'd12000, Q_MIN, Q_MAX, '0));
        // products of -1 LSB must round towards minus infinity
        send_item(mk_item(-32'sd1, -32'sd1, -32'sd1, 16'd40000, -32'sd1, -32'sd1, -32'sd1));
        // negated rail in the Park rotation
        send_item(mk_item('0, '0, '0, 16'd40000, Q_MIN, Q_MIN, Q_MIN));
        settle();
    endtask

    // all registers at their top value, then Ld below Lq
    task automatic test_reg_extremes();
        plan_regs('1, '1, '1, '1, '1, '1, '1);
        write_regs();
        send_item(mk_item('0, '0, '0, 16'd0, '0, '0, '0));
        send_item(mk_item(Q_MAX, Q_MAX, Q_MAX, 16'hffff, Q_MAX, Q_MAX, Q_MAX));
        send_item(mk_item(32'sd65536, -32'sd65536, 32'sd655360, 16'd20000,
                          32'sd65536, 32'sd65536, Q_MIN));
        settle();
        plan_regs(31'd65536, '0, '1, 31'd65536, 31'd65536, 31'd65536, 31'd65536);
        write_regs();
        send_item(mk_item(32'sd131072, 32'sd131072, 32'sd65536, 16'd30000,
                          32'sd65536, 32'sd65536, 32'sd65536));
        send_item(mk_item(Q_MIN, Q_MAX, Q_MIN, 16'd50000, Q_MAX, Q_MIN, Q_MAX));
        settle();
    endtask

    // random transactions over two register sets under one idling pattern
    task automatic test_random_traffic(input int sp, input int rp, input int n);
        send_idle_pct  = sp;
        recv_stall_pct = rp;
        for (int set = 0; set < 2; set++) begin
            for (int g = 0; g < NREG; g++) reg_plan[g] = rand_reg();
            settle();
            write_regs();
            for (int j = 0; j < n / 2; j++) send_item(rand_item());
        end
        settle();
    endtask

    // long receiver hold-off while the sender keeps pushing, then a full drain
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        for (int g = 0; g < NREG; g++) reg_plan[g] = rand_reg();
        settle();
        write_regs();
        hold_cycles = 80;
        for (int j = 0; j < 40; j++) send_item(rand_item());
        settle();
    endtask

    initial begin
        for (int n = 0; n < NREG; n++) begin
            cfg_reg[n]  = '0;
            reg_plan[n] = '0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_regs();
        test_field_extremes();
        test_reg_extremes();
        test_random_traffic(0, 0, 120);
        test_random_traffic(47, 0, 110);
        test_random_traffic(0, 47, 110);
        test_random_traffic(29, 29, 120);
        test_backpressure();

        // tail: let any stray result show up
        settle();
        repeat (DQ_LAT * 3) @(posedge i_clk);
        if (mismatch_count == 0 && pending_derivs.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/ipmdq_pkg.sv
rtl/ipm_motor_dq_derivatives_core.sv
rtl/ipmdq_chk.sv
tb/sv/ipm_motor_dq_derivatives_core_tb.sv
